// ===== rtl/sync_word_frame_receiver_ack_assert.svh =====
// Assertion macros used by the checker of the frame receiver.
`ifndef SYNC_WORD_FRAME_RECEIVER_ACK_ASSERT_SVH
`define SYNC_WORD_FRAME_RECEIVER_ACK_ASSERT_SVH

// Same-cycle implication, disabled while rst_n is low.
`define SWFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while rst_n is low.
`define SWFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/swfr_pkg.sv =====
package swfr_pkg;

    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;
    localparam int SYNC_W = 32;
    localparam int CNT_W  = 32;
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 32;
    localparam int KIND_W = 2;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NAK     = 2'd2;

    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_OVERRUN = 1'b1;

    localparam logic [CFG_AW-1:0] REG_SYNC_WORD   = 2'd0;
    localparam logic [CFG_AW-1:0] REG_PAYLOAD_LEN = 2'd1;
    localparam logic [CFG_AW-1:0] REG_ACK_BYTE    = 2'd2;
    localparam logic [CFG_AW-1:0] REG_NAK_BYTE    = 2'd3;

    localparam logic [SYNC_W-1:0] RST_SYNC_WORD   = 32'hABCD_EF12;
    localparam logic [LEN_W-1:0]  RST_PAYLOAD_LEN = 6'd32;
    localparam logic [BYTE_W-1:0] RST_ACK_BYTE    = 8'h06;
    localparam logic [BYTE_W-1:0] RST_NAK_BYTE    = 8'h15;

    // One unit of work for the output side: a finished frame or an overrun.
    typedef struct packed {
        logic              is_nak;
        logic [LEN_W-1:0]  count;
        logic [BYTE_W-1:0] code;
        logic [CNT_W-1:0]  total;
    } t_job;

endpackage

// ===== rtl/swfr_ram.sv =====
module swfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/swfr_fifo.sv =====
module swfr_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  swfr_pkg::t_job  i_data,
    input  logic            i_pop,
    output swfr_pkg::t_job  o_data,
    output logic            o_empty,
    output logic            o_full
);

    swfr_pkg::t_job r_slot [0:1];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    assign o_data  = r_slot[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

endmodule

// ===== rtl/swfr_front.sv =====
module swfr_front #(
    parameter int MAX_PAYLOAD = 32,
    parameter int IW          = 6,
    parameter int AW          = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [swfr_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [swfr_pkg::CFG_DW-1:0]   i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_cmd,
    input  logic [swfr_pkg::BYTE_W-1:0]   i_byte,
    output logic                          o_ram_we,
    output logic [AW-1:0]                 o_ram_addr,
    output logic [swfr_pkg::BYTE_W-1:0]   o_ram_wdata,
    output logic                          o_push,
    output swfr_pkg::t_job                o_job,
    input  logic                          i_fifo_full,
    input  logic                          i_frame_busy
);

    typedef enum logic [2:0] {
        H_SYNC0,
        H_SYNC1,
        H_SYNC2,
        H_SYNC3,
        H_RECV
    } t_hunt_e;

    t_hunt_e                       r_state, n_state;
    logic [IW-1:0]                 r_idx, n_idx;
    logic [swfr_pkg::CNT_W-1:0]    r_ovr, n_ovr;
    logic [swfr_pkg::SYNC_W-1:0]   r_sync;
    logic [swfr_pkg::LEN_W-1:0]    r_len;
    logic [swfr_pkg::BYTE_W-1:0]   r_ack;
    logic [swfr_pkg::BYTE_W-1:0]   r_nak;

    logic                          accept;
    logic [swfr_pkg::BYTE_W-1:0]   expect_byte;
    logic [swfr_pkg::LEN_W-1:0]    eff_len;
    logic [swfr_pkg::LEN_W-1:0]    len_lim;
    logic [IW-1:0]                 idx_inc;

    assign len_lim = swfr_pkg::LEN_W'(MAX_PAYLOAD);
    assign eff_len = (r_len == '0) ? swfr_pkg::LEN_W'(1) :
                     (r_len > len_lim) ? len_lim : r_len;
    assign idx_inc = r_idx + IW'(1);

    // Stall every byte while the queue is full, and payload bytes until the previous frame has left the store.
    assign o_ready = !i_fifo_full && !(r_state == H_RECV && i_frame_busy);
    assign accept  = i_valid && o_ready;

    always_comb begin
        unique case (r_state)
            H_SYNC0: expect_byte = r_sync[31:24];
            H_SYNC1: expect_byte = r_sync[23:16];
            H_SYNC2: expect_byte = r_sync[15:8];
            H_SYNC3: expect_byte = r_sync[7:0];
            default: expect_byte = r_sync[31:24];
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_ovr       = r_ovr;
        o_ram_we    = 1'b0;
        o_ram_addr  = r_idx[AW-1:0];
        o_ram_wdata = i_byte;
        o_push      = 1'b0;
        o_job       = '{is_nak: 1'b0, count: swfr_pkg::LEN_W'(idx_inc),
                        code: r_ack, total: r_ovr};
        if (accept) begin
            if (i_cmd == swfr_pkg::CMD_OVERRUN) begin
                if (r_ovr != '1) begin
                    n_ovr = r_ovr + swfr_pkg::CNT_W'(1);
                end
                n_state      = H_SYNC0;
                n_idx        = '0;
                o_push       = 1'b1;
                o_job.is_nak = 1'b1;
                o_job.code   = r_nak;
                o_job.total  = n_ovr;
            end else if (r_state == H_RECV) begin
                o_ram_we = 1'b1;
                n_idx    = idx_inc;
                if (swfr_pkg::LEN_W'(idx_inc) >= eff_len) begin
                    o_push  = 1'b1;
                    n_state = H_SYNC0;
                    n_idx   = '0;
                end
            end else if (i_byte == expect_byte) begin
                unique case (r_state)
                    H_SYNC0: n_state = H_SYNC1;
                    H_SYNC1: n_state = H_SYNC2;
                    H_SYNC2: n_state = H_SYNC3;
                    default: begin
                        n_state = H_RECV;
                        n_idx   = '0;
                    end
                endcase
            end else begin
                n_state = H_SYNC0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_SYNC0;
            r_idx   <= '0;
            r_ovr   <= '0;
            r_sync  <= swfr_pkg::RST_SYNC_WORD;
            r_len   <= swfr_pkg::RST_PAYLOAD_LEN;
            r_ack   <= swfr_pkg::RST_ACK_BYTE;
            r_nak   <= swfr_pkg::RST_NAK_BYTE;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_ovr   <= n_ovr;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    swfr_pkg::REG_SYNC_WORD:   r_sync <= i_cfg_wdata;
                    swfr_pkg::REG_PAYLOAD_LEN: r_len  <= i_cfg_wdata[swfr_pkg::LEN_W-1:0];
                    swfr_pkg::REG_ACK_BYTE:    r_ack  <= i_cfg_wdata[swfr_pkg::BYTE_W-1:0];
                    swfr_pkg::REG_NAK_BYTE:    r_nak  <= i_cfg_wdata[swfr_pkg::BYTE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== rtl/swfr_back.sv =====
module swfr_back #(
    parameter int IW = 6,
    parameter int AW = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  swfr_pkg::t_job                i_job,
    output logic                          o_pop,
    output logic                          o_ram_re,
    output logic [AW-1:0]                 o_ram_addr,
    input  logic [swfr_pkg::BYTE_W-1:0]   i_ram_rdata,
    output logic                          o_busy,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [swfr_pkg::KIND_W-1:0]   o_kind,
    output logic [swfr_pkg::BYTE_W-1:0]   o_byte,
    output logic                          o_last,
    output logic [swfr_pkg::CNT_W-1:0]    o_total
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_RD,
        B_DAT,
        B_LAST
    } t_back_e;

    t_back_e                       r_state;
    swfr_pkg::t_job                r_job;
    logic [IW-1:0]                 r_i;
    logic                          r_vld;
    logic [swfr_pkg::KIND_W-1:0]   r_kind;
    logic [swfr_pkg::BYTE_W-1:0]   r_byte;
    logic                          r_last;
    logic [swfr_pkg::CNT_W-1:0]    r_total;
    logic                          out_free;
    logic                          load;

    assign out_free   = !r_vld || i_ready;
    assign load       = out_free && (r_state == B_DAT || r_state == B_LAST);
    assign o_pop      = (r_state == B_IDLE) && !i_empty;
    assign o_ram_re   = (r_state == B_RD);
    assign o_ram_addr = r_i[AW-1:0];
    assign o_busy     = (r_state != B_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_vld   <= 1'b0;
        end else begin
            if (r_vld && i_ready && !load) begin
                r_vld <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= i_job;
                        r_i     <= '0;
                        r_state <= i_job.is_nak ? B_LAST : B_RD;
                    end
                end
                B_RD: begin
                    r_state <= B_DAT;
                end
                B_DAT: begin
                    if (out_free) begin
                        r_vld   <= 1'b1;
                        r_kind  <= swfr_pkg::KIND_PAYLOAD;
                        r_byte  <= i_ram_rdata;
                        r_last  <= 1'b0;
                        r_total <= r_job.total;
                        r_i     <= r_i + IW'(1);
                        if (swfr_pkg::LEN_W'(r_i) + swfr_pkg::LEN_W'(1) == r_job.count) begin
                            r_state <= B_LAST;
                        end else begin
                            r_state <= B_RD;
                        end
                    end
                end
                B_LAST: begin
                    if (out_free) begin
                        r_vld   <= 1'b1;
                        r_kind  <= r_job.is_nak ? swfr_pkg::KIND_NAK : swfr_pkg::KIND_ACK;
                        r_byte  <= r_job.code;
                        r_last  <= 1'b1;
                        r_total <= r_job.total;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_valid = r_vld;
    assign o_kind  = r_kind;
    assign o_byte  = r_byte;
    assign o_last  = r_last;
    assign o_total = r_total;

endmodule

// ===== rtl/sync_word_frame_receiver_ack.sv =====
// Sync-word frame receiver with acknowledge.
// Input stream: s_axis_tuser is the command (0 received byte, 1 overrun event),
// s_axis_tdata the received byte. Output stream: m_axis_tuser is the result kind
// (payload, ack, nak), m_axis_tdata holds the byte and the overrun count, and
// m_axis_tlast marks the ack or nak that closes the results of one input item.
// The receive side hunts for the four sync bytes, writes the payload into a RAM
// and hands a job (frame done or overrun) through a two-entry queue to the send
// side, which reads the RAM back and streams the bytes.
// A nak passes from the queue into the job register and then the output register;
// each payload byte of a frame is read from the RAM, then loaded into the output
// register, and the ack follows the last byte.
// A payload byte is held off while a previous frame is still being sent; an
// output stall holds the output register and backs up through the queue.
// Synchronous reset restores the register defaults, clears the hunt, the overrun
// count, the queue and the output; the payload RAM is not cleared.
module sync_word_frame_receiver_ack #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [swfr_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [swfr_pkg::CFG_DW-1:0] i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // rx_byte
    input  logic                        s_axis_tuser,  // cmd
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [39:0]                 m_axis_tdata,  // out_byte, overrun_total
    output logic [1:0]                  m_axis_tuser,  // out_kind
    output logic                        m_axis_tlast   // last
);

    localparam int IW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [swfr_pkg::BYTE_W-1:0]   ram_wdata;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [swfr_pkg::BYTE_W-1:0]   ram_rdata;
    logic                          push;
    logic                          pop;
    swfr_pkg::t_job                job_in;
    swfr_pkg::t_job                job_out;
    logic                          fifo_empty;
    logic                          fifo_full;
    logic                          back_busy;
    logic                          frame_busy;
    logic [swfr_pkg::BYTE_W-1:0]   out_byte;
    logic [swfr_pkg::CNT_W-1:0]    out_total;

    assign frame_busy = !fifo_empty || back_busy;

    swfr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .IW          (IW),
        .AW          (AW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_cmd        (s_axis_tuser),
        .i_byte       (s_axis_tdata),
        .o_ram_we     (ram_we),
        .o_ram_addr   (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_push       (push),
        .o_job        (job_in),
        .i_fifo_full  (fifo_full),
        .i_frame_busy (frame_busy)
    );

    swfr_ram #(
        .WIDTH (swfr_pkg::BYTE_W),
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    swfr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_empty (fifo_empty),
        .o_full  (fifo_full)
    );

    swfr_back #(
        .IW (IW),
        .AW (AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (fifo_empty),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_ram_re    (ram_re),
        .o_ram_addr  (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_busy      (back_busy),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_kind      (m_axis_tuser),
        .o_byte      (out_byte),
        .o_last      (m_axis_tlast),
        .o_total     (out_total)
    );

    assign m_axis_tdata = {out_total, out_byte};

endmodule

// ===== rtl/swfr_checker.sv =====
`include "sync_word_frame_receiver_ack_assert.svh"

module swfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    `SWFR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")
    `SWFR_ASSERT_NOW(a_last_kind, i_clk, i_rst_n, m_axis_tvalid, m_axis_tlast == (m_axis_tuser != swfr_pkg::KIND_PAYLOAD), "tlast does not match result kind")
    `SWFR_ASSERT_NOW(a_nak_count, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == swfr_pkg::KIND_NAK, m_axis_tdata[39:8] != 32'd0, "nak with zero overrun count")
    `SWFR_ASSERT_NEXT(a_rst_quiet, i_clk, 1'b1, !i_rst_n, !m_axis_tvalid, "output valid after reset")

endmodule

bind sync_word_frame_receiver_ack swfr_checker u_swfr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
